[src/rrs_pkg.sv]
// Shared types, constants and register map for the raycaster ray setup block.
package rrs_pkg;

    localparam int SCREEN_WIDTH = 640;
    localparam int MAP_CELLS    = 64;

    // Camera coordinate: floor(column * 2^17 / SCREEN_WIDTH) by a reciprocal multiply.
    localparam int CAM_K   = 40;
    localparam int CAM_SH  = CAM_K - 17;
    localparam logic [39:0] CAM_M =
        40'(((64'd1 << CAM_K) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));

    localparam logic signed [31:0] RAY_MAX = 32'sd524287;
    localparam logic signed [31:0] RAY_MIN = -32'sd524288;

    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = 32 / DIV_STEPS;

    localparam logic [2:0] REG_POS_X       = 3'd0;
    localparam logic [2:0] REG_POS_Y       = 3'd1;
    localparam logic [2:0] REG_VIEW_DIR_X  = 3'd2;
    localparam logic [2:0] REG_VIEW_DIR_Y  = 3'd3;
    localparam logic [2:0] REG_CAM_PLANE_X = 3'd4;
    localparam logic [2:0] REG_CAM_PLANE_Y = 3'd5;

    typedef struct packed {
        logic [21:0]        pos_x;
        logic [21:0]        pos_y;
        logic signed [18:0] view_dir_x;
        logic signed [18:0] view_dir_y;
        logic signed [18:0] cam_plane_x;
        logic signed [18:0] cam_plane_y;
    } t_cfg;

    typedef struct packed {
        logic [19:0] mag;
        logic [20:0] rem;
        logic [31:0] quo;
    } t_dlane;

    typedef struct packed {
        logic signed [19:0] ray_x;
        logic signed [19:0] ray_y;
        t_dlane             lx;
        t_dlane             ly;
    } t_dpipe;

    typedef struct packed {
        logic signed [19:0] ray_x;
        logic signed [19:0] ray_y;
        logic [5:0]         cell_x;
        logic [5:0]         cell_y;
        logic               step_x_negative;
        logic               step_y_negative;
        logic [31:0]        delta_x;
        logic [31:0]        delta_y;
        logic [31:0]        side_x;
        logic [31:0]        side_y;
    } t_result;

endpackage

[src/rrs_in_if.sv]
// Input channel carrying one screen column per item.
interface rrs_in_if;
    logic       valid;
    logic       ready;
    logic [9:0] column;
    modport source(output valid, output column, input ready);
    modport sink(input valid, input column, output ready);
endinterface

[src/rrs_out_if.sv]
// Output channel carrying one ray setup result per item.
interface rrs_out_if;
    logic               valid;
    logic               ready;
    logic signed [19:0] ray_x;
    logic signed [19:0] ray_y;
    logic [5:0]         cell_x;
    logic [5:0]         cell_y;
    logic               step_x_negative;
    logic               step_y_negative;
    logic [31:0]        delta_x;
    logic [31:0]        delta_y;
    logic [31:0]        side_x;
    logic [31:0]        side_y;
    modport source(output valid, output ray_x, output ray_y, output cell_x, output cell_y,
                   output step_x_negative, output step_y_negative, output delta_x,
                   output delta_y, output side_x, output side_y, input ready);
    modport sink(input valid, input ray_x, input ray_y, input cell_x, input cell_y,
                 input step_x_negative, input step_y_negative, input delta_x,
                 input delta_y, input side_x, input side_y, output ready);
endinterface

[src/raycast_ray_setup_core.sv]
// Top level of the raycaster ray setup pipeline.
//
//  Channel     Direction  Handshake           Carries
//  i_col_ch    in         valid/ready         column
//  o_ray_ch    out        valid/ready         ray, cell, step, delta, side per axis
//  APB         in/out     psel/penable        position, view direction, camera plane
//
// One item is accepted every cycle while the output is not stalled. Each item
// passes through 3 ray stages, 8 reciprocal stages of four division steps each,
// and 3 cell, offset and side-distance stages, the last being the output register.
// The whole pipeline advances together whenever the output register is empty or
// its item is being taken, so a stall at the output freezes every stage in place.
// Reset is synchronous and active low; it clears the valid bits and loads the
// register defaults.
module raycast_ray_setup_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rrs_in_if.sink        i_col_ch,
    rrs_out_if.source     o_ray_ch,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    rrs_pkg::t_cfg    cfg;
    logic             en;
    logic             ray_valid;
    rrs_pkg::t_dpipe  ray_item;
    logic             div_valid [rrs_pkg::DIV_STAGES+1];
    rrs_pkg::t_dpipe  div_item  [rrs_pkg::DIV_STAGES+1];
    logic             res_valid;
    rrs_pkg::t_result res;

    // The pipeline moves when the output register can take a new item.
    assign en             = !res_valid || o_ray_ch.ready;
    assign i_col_ch.ready = en;

    rrs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rrs_ray u_ray (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_col_ch.valid),
        .i_column (i_col_ch.column),
        .i_cfg    (cfg),
        .o_valid  (ray_valid),
        .o_item   (ray_item)
    );

    assign div_valid[0] = ray_valid;
    assign div_item[0]  = ray_item;

    // The reciprocal 2^32 / |ray| is built four quotient bits per stage.
    for (genvar s = 0; s < rrs_pkg::DIV_STAGES; s++) begin : g_div
        rrs_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (div_valid[s]),
            .i_item  (div_item[s]),
            .o_valid (div_valid[s+1]),
            .o_item  (div_item[s+1])
        );
    end

    rrs_side u_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_valid[rrs_pkg::DIV_STAGES]),
        .i_item  (div_item[rrs_pkg::DIV_STAGES]),
        .i_cfg   (cfg),
        .o_valid (res_valid),
        .o_res   (res)
    );

    assign o_ray_ch.valid           = res_valid;
    assign o_ray_ch.ray_x           = res.ray_x;
    assign o_ray_ch.ray_y           = res.ray_y;
    assign o_ray_ch.cell_x          = res.cell_x;
    assign o_ray_ch.cell_y          = res.cell_y;
    assign o_ray_ch.step_x_negative = res.step_x_negative;
    assign o_ray_ch.step_y_negative = res.step_y_negative;
    assign o_ray_ch.delta_x         = res.delta_x;
    assign o_ray_ch.delta_y         = res.delta_y;
    assign o_ray_ch.side_x          = res.side_x;
    assign o_ray_ch.side_y          = res.side_y;
endmodule

[src/rrs_cfg.sv]
// APB configuration registers for position, view direction and camera plane.
module rrs_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output rrs_pkg::t_cfg     o_cfg
);
    rrs_pkg::t_cfg r_cfg;
    logic [2:0]    idx;

    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pos_x       <= '0;
            r_cfg.pos_y       <= '0;
            r_cfg.view_dir_x  <= 19'sd65536;
            r_cfg.view_dir_y  <= '0;
            r_cfg.cam_plane_x <= '0;
            r_cfg.cam_plane_y <= 19'sd43254;
        end else if (psel && penable && pwrite) begin
            case (idx)
                rrs_pkg::REG_POS_X:       r_cfg.pos_x       <= pwdata[21:0];
                rrs_pkg::REG_POS_Y:       r_cfg.pos_y       <= pwdata[21:0];
                rrs_pkg::REG_VIEW_DIR_X:  r_cfg.view_dir_x  <= $signed(pwdata[18:0]);
                rrs_pkg::REG_VIEW_DIR_Y:  r_cfg.view_dir_y  <= $signed(pwdata[18:0]);
                rrs_pkg::REG_CAM_PLANE_X: r_cfg.cam_plane_x <= $signed(pwdata[18:0]);
                rrs_pkg::REG_CAM_PLANE_Y: r_cfg.cam_plane_y <= $signed(pwdata[18:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            rrs_pkg::REG_POS_X:       prdata = {10'd0, r_cfg.pos_x};
            rrs_pkg::REG_POS_Y:       prdata = {10'd0, r_cfg.pos_y};
            rrs_pkg::REG_VIEW_DIR_X:  prdata = {13'd0, r_cfg.view_dir_x};
            rrs_pkg::REG_VIEW_DIR_Y:  prdata = {13'd0, r_cfg.view_dir_y};
            rrs_pkg::REG_CAM_PLANE_X: prdata = {13'd0, r_cfg.cam_plane_x};
            rrs_pkg::REG_CAM_PLANE_Y: prdata = {13'd0, r_cfg.cam_plane_y};
            default:                  prdata = '0;
        endcase
    end
endmodule

[src/rrs_ray.sv]
// Ray direction stages: camera coordinate, plane products, saturated ray sum.
module rrs_ray (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [9:0]        i_column,
    input  rrs_pkg::t_cfg     i_cfg,
    output logic              o_valid,
    output rrs_pkg::t_dpipe   o_item
);
    logic                r_s1_valid;
    logic [49:0]         r_s1_prod;
    logic                r_s2_valid;
    logic signed [46:0]  r_s2_px;
    logic signed [46:0]  r_s2_py;
    logic                r_s3_valid;
    rrs_pkg::t_dpipe     r_s3_item;

    logic signed [27:0]  camera;
    logic signed [19:0]  ray_x;
    logic signed [19:0]  ray_y;
    rrs_pkg::t_dpipe     n_s3_item;

    function automatic logic signed [19:0] ray_sat(logic signed [18:0] dir,
                                                   logic signed [46:0] prod);
        logic signed [31:0] sum;
        sum = 32'(dir) + 32'(prod >>> 16);
        if (sum > rrs_pkg::RAY_MAX)      ray_sat = 20'sd262143 * 2 + 20'sd1;
        else if (sum < rrs_pkg::RAY_MIN) ray_sat = -20'sd262144 * 2;
        else                             ray_sat = sum[19:0];
    endfunction

    function automatic logic [19:0] mag_of(logic signed [19:0] r);
        mag_of = r[19] ? 20'(-r) : 20'(r);
    endfunction

    assign camera = $signed({1'b0, 27'(r_s1_prod >> rrs_pkg::CAM_SH)}) - 28'sd65536;
    assign ray_x  = ray_sat(i_cfg.view_dir_x, r_s2_px);
    assign ray_y  = ray_sat(i_cfg.view_dir_y, r_s2_py);

    always_comb begin
        n_s3_item.ray_x  = ray_x;
        n_s3_item.ray_y  = ray_y;
        n_s3_item.lx.mag = mag_of(ray_x);
        n_s3_item.lx.rem = 21'd1;
        n_s3_item.lx.quo = '0;
        n_s3_item.ly.mag = mag_of(ray_y);
        n_s3_item.ly.rem = 21'd1;
        n_s3_item.ly.quo = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_prod <= 50'(i_column) * 50'(rrs_pkg::CAM_M);
            r_s2_px   <= 47'(i_cfg.cam_plane_x) * 47'(camera);
            r_s2_py   <= 47'(i_cfg.cam_plane_y) * 47'(camera);
            r_s3_item <= n_s3_item;
        end
    end

    assign o_valid = r_s3_valid;
    assign o_item  = r_s3_item;
endmodule

[src/rrs_div_stage.sv]
// One reciprocal stage: a few restoring division steps on both axes.
module rrs_div_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  rrs_pkg::t_dpipe   i_item,
    output logic              o_valid,
    output rrs_pkg::t_dpipe   o_item
);
    logic            r_valid;
    rrs_pkg::t_dpipe r_item;
    rrs_pkg::t_dpipe n_item;

    function automatic rrs_pkg::t_dlane steps(rrs_pkg::t_dlane l);
        rrs_pkg::t_dlane v;
        logic [20:0]     r2;
        v = l;
        for (int k = 0; k < rrs_pkg::DIV_STEPS; k++) begin
            r2 = {v.rem[19:0], 1'b0};
            if (r2 >= {1'b0, v.mag}) begin
                v.rem = r2 - {1'b0, v.mag};
                v.quo = {v.quo[30:0], 1'b1};
            end else begin
                v.rem = r2;
                v.quo = {v.quo[30:0], 1'b0};
            end
        end
        steps = v;
    endfunction

    always_comb begin
        n_item    = i_item;
        n_item.lx = steps(i_item.lx);
        n_item.ly = steps(i_item.ly);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

[src/rrs_side.sv]
// Delta, map cell, grid offset and saturated side distance stages.
module rrs_side (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  rrs_pkg::t_dpipe   i_item,
    input  rrs_pkg::t_cfg     i_cfg,
    output logic              o_valid,
    output rrs_pkg::t_result  o_res
);
    logic             r_a_valid;
    rrs_pkg::t_result r_a_res;
    logic [22:0]      r_a_off_x;
    logic [22:0]      r_a_off_y;
    logic             r_b_valid;
    rrs_pkg::t_result r_b_res;
    logic [54:0]      r_b_px;
    logic [54:0]      r_b_py;
    logic             r_b_offz_x;
    logic             r_b_offz_y;
    logic             r_c_valid;
    rrs_pkg::t_result r_c_res;
    rrs_pkg::t_result n_a_res;
    rrs_pkg::t_result n_c_res;

    function automatic logic [5:0] cell_of(logic [21:0] pos);
        if (32'(pos[21:16]) > rrs_pkg::MAP_CELLS - 1) cell_of = 6'(rrs_pkg::MAP_CELLS - 1);
        else                                          cell_of = pos[21:16];
    endfunction

    function automatic logic [22:0] off_of(logic [21:0] pos, logic neg);
        logic [22:0] base;
        logic [22:0] edge_p;
        base   = {1'b0, cell_of(pos), 16'd0};
        edge_p = base + 23'd65536;
        if (neg)                     off_of = {1'b0, pos} - base;
        else if ({1'b0, pos} > edge_p) off_of = '0;
        else                         off_of = edge_p - {1'b0, pos};
    endfunction

    function automatic logic [31:0] side_of(logic [31:0] delta, logic offz, logic [54:0] p);
        logic [38:0] s;
        s = 39'(p >> 16);
        if (delta == '1)    side_of = offz ? '0 : '1;
        else if (s[38:32] != '0) side_of = '1;
        else                side_of = s[31:0];
    endfunction

    always_comb begin
        n_a_res                 = '0;
        n_a_res.ray_x           = i_item.ray_x;
        n_a_res.ray_y           = i_item.ray_y;
        n_a_res.cell_x          = cell_of(i_cfg.pos_x);
        n_a_res.cell_y          = cell_of(i_cfg.pos_y);
        n_a_res.step_x_negative = i_item.ray_x[19];
        n_a_res.step_y_negative = i_item.ray_y[19];
        // A magnitude of zero or one makes the reciprocal infinite or too large.
        n_a_res.delta_x = (i_item.lx.mag <= 20'd1) ? '1 : i_item.lx.quo;
        n_a_res.delta_y = (i_item.ly.mag <= 20'd1) ? '1 : i_item.ly.quo;
    end

    always_comb begin
        n_c_res        = r_b_res;
        n_c_res.side_x = side_of(r_b_res.delta_x, r_b_offz_x, r_b_px);
        n_c_res.side_y = side_of(r_b_res.delta_y, r_b_offz_y, r_b_py);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_res    <= n_a_res;
            r_a_off_x  <= off_of(i_cfg.pos_x, i_item.ray_x[19]);
            r_a_off_y  <= off_of(i_cfg.pos_y, i_item.ray_y[19]);
            r_b_res    <= r_a_res;
            r_b_px     <= 55'(r_a_off_x) * 55'(r_a_res.delta_x);
            r_b_py     <= 55'(r_a_off_y) * 55'(r_a_res.delta_y);
            r_b_offz_x <= (r_a_off_x == '0);
            r_b_offz_y <= (r_a_off_y == '0);
            r_c_res    <= n_c_res;
        end
    end

    assign o_valid = r_c_valid;
    assign o_res   = r_c_res;
endmodule

[sim/tb_raycast_ray_setup_core.sv]
// Testbench for the raycaster ray setup core: directed and random columns checked against a predictor.
module tb_raycast_ray_setup_core;

    // Expected results of the accepted columns, oldest first, with a self-contained predictor
    // of the ray setup arithmetic under the current register settings.
    class ray_setup_board;
        rrs_pkg::t_result pending[$];
        int      errors;
        logic [21:0] px, py;
        logic signed [18:0] dx, dy, plx, ply;

        function void reset_regs();
            px = '0; py = '0; dx = 19'sd65536; dy = '0; plx = '0; ply = 19'sd43254;
            errors = 0;
        endfunction

        function longint ray_of(longint d, longint pl, longint cam);
            longint prod, r;
            prod = pl * cam;
            if (prod >= 0) r = d + prod / 65536;
            else r = d - ((-prod + 65535) / 65536);
            if (r > 524287) r = 524287;
            if (r < -524288) r = -524288;
            return r;
        endfunction

        function logic [63:0] inv_of(longint r);
            logic [63:0] q;
            if (r == 0) return 64'hFFFF_FFFF;
            q = (64'd1 << 32) / ((r < 0) ? -r : r);
            if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
            return q;
        endfunction

        function void axis_of(logic [21:0] pos, longint r, logic [63:0] dl,
                              output logic [5:0] map_cell, output logic [31:0] side);
            logic [63:0] c, base, off, prod;
            c = pos >> 16;
            if (c > rrs_pkg::MAP_CELLS - 1) c = rrs_pkg::MAP_CELLS - 1;
            base = c * 65536;
            if (r < 0) off = pos - base;
            else off = (pos > base + 65536) ? 0 : base + 65536 - pos;
            if (dl == 64'hFFFF_FFFF) prod = (off == 0) ? 0 : 64'hFFFF_FFFF;
            else begin
                prod = (off * dl) >> 16;
                if (prod > 64'hFFFF_FFFF) prod = 64'hFFFF_FFFF;
            end
            map_cell = c[5:0];
            side = prod[31:0];
        endfunction

        function void note_column(logic [9:0] col);
            rrs_pkg::t_result e;
            longint cam, rx, ry;
            logic [63:0] ddx, ddy;
            cam = longint'((64'(col) * 2 * 65536) / rrs_pkg::SCREEN_WIDTH) - 65536;
            rx = ray_of(dx, plx, cam);
            ry = ray_of(dy, ply, cam);
            ddx = inv_of(rx);
            ddy = inv_of(ry);
            e.ray_x = rx[19:0];
            e.ray_y = ry[19:0];
            e.step_x_negative = rx < 0;
            e.step_y_negative = ry < 0;
            e.delta_x = ddx[31:0];
            e.delta_y = ddy[31:0];
            axis_of(px, rx, ddx, e.cell_x, e.side_x);
            axis_of(py, ry, ddy, e.cell_y, e.side_y);
            pending.push_back(e);
        endfunction

        function void check_ray(rrs_pkg::t_result got);
            rrs_pkg::t_result e;
            if (pending.size() == 0) begin
                $display("%0t: result with nothing expected, got %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.ray_x !== e.ray_x) begin
                $display("%0t: ray_x exp %h got %h", $time, e.ray_x, got.ray_x); errors++; end
            if (got.ray_y !== e.ray_y) begin
                $display("%0t: ray_y exp %h got %h", $time, e.ray_y, got.ray_y); errors++; end
            if (got.cell_x !== e.cell_x) begin
                $display("%0t: cell_x exp %h got %h", $time, e.cell_x, got.cell_x); errors++; end
            if (got.cell_y !== e.cell_y) begin
                $display("%0t: cell_y exp %h got %h", $time, e.cell_y, got.cell_y); errors++; end
            if (got.step_x_negative !== e.step_x_negative) begin
                $display("%0t: step_x_negative exp %b got %b", $time,
                         e.step_x_negative, got.step_x_negative); errors++; end
            if (got.step_y_negative !== e.step_y_negative) begin
                $display("%0t: step_y_negative exp %b got %b", $time,
                         e.step_y_negative, got.step_y_negative); errors++; end
            if (got.delta_x !== e.delta_x) begin
                $display("%0t: delta_x exp %h got %h", $time, e.delta_x, got.delta_x); errors++; end
            if (got.delta_y !== e.delta_y) begin
                $display("%0t: delta_y exp %h got %h", $time, e.delta_y, got.delta_y); errors++; end
            if (got.side_x !== e.side_x) begin
                $display("%0t: side_x exp %h got %h", $time, e.side_x, got.side_x); errors++; end
            if (got.side_y !== e.side_y) begin
                $display("%0t: side_y exp %h got %h", $time, e.side_y, got.side_y); errors++; end
        endfunction
    endclass

    localparam int PIPE_CYCLES = 14;
    localparam longint CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    rrs_in_if  col_ch();
    rrs_out_if ray_ch();

    raycast_ray_setup_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_col_ch(col_ch.sink), .o_ray_ch(ray_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    ray_setup_board board = new();
    longint cycles = 0;
    bit     calm = 1'b0;      // no idling in the last part of the run
    bit     hold_off = 1'b0;  // long receiver stall to fill the pipeline
    int     col_count = 0;

    initial begin
        col_ch.valid = 1'b0;
        col_ch.column = '0;
        ray_ch.ready = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Cycle counter doubling as the watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_raycast_ray_setup_core: done, errors");
            $finish;
        end
    end

    // Monitor: note accepted columns and check accepted results in the same edge.
    always @(posedge i_clk) begin
        rrs_pkg::t_result got;
        if (i_rst_n && col_ch.valid && col_ch.ready) begin
            board.note_column(col_ch.column);
            col_count++;
        end
        if (i_rst_n && ray_ch.valid && ray_ch.ready) begin
            got.ray_x = ray_ch.ray_x; got.ray_y = ray_ch.ray_y;
            got.cell_x = ray_ch.cell_x; got.cell_y = ray_ch.cell_y;
            got.step_x_negative = ray_ch.step_x_negative;
            got.step_y_negative = ray_ch.step_y_negative;
            got.delta_x = ray_ch.delta_x; got.delta_y = ray_ch.delta_y;
            got.side_x = ray_ch.side_x; got.side_y = ray_ch.side_y;
            board.check_ray(got);
        end
    end

    // Receiver: random stall bursts unless calm; a long hold-off when asked.
    initial begin : sink_proc
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                ray_ch.ready <= 1'b0;
                repeat (60) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 14);
                ray_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                ray_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk iff pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            rrs_pkg::REG_POS_X:       board.px  = val[21:0];
            rrs_pkg::REG_POS_Y:       board.py  = val[21:0];
            rrs_pkg::REG_VIEW_DIR_X:  board.dx  = val[18:0];
            rrs_pkg::REG_VIEW_DIR_Y:  board.dy  = val[18:0];
            rrs_pkg::REG_CAM_PLANE_X: board.plx = val[18:0];
            rrs_pkg::REG_CAM_PLANE_Y: board.ply = val[18:0];
            default: ;
        endcase
    endtask

    // Sends one column, holding valid until accepted; random gaps before it.
    task automatic send_column(input logic [9:0] col);
        int n;
        if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 14);
            col_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        col_ch.valid <= 1'b1;
        col_ch.column <= col;
        @(posedge i_clk iff col_ch.ready);
    endtask

    task automatic drain();
        col_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_CYCLES + 3) @(posedge i_clk);
    endtask

    task automatic set_view(input logic [31:0] pxv, pyv, dxv, dyv, plxv, plyv);
        apb_write(rrs_pkg::REG_POS_X, pxv);
        apb_write(rrs_pkg::REG_POS_Y, pyv);
        apb_write(rrs_pkg::REG_VIEW_DIR_X, dxv);
        apb_write(rrs_pkg::REG_VIEW_DIR_Y, dyv);
        apb_write(rrs_pkg::REG_CAM_PLANE_X, plxv);
        apb_write(rrs_pkg::REG_CAM_PLANE_Y, plyv);
    endtask

    function automatic logic [31:0] rand_dir();
        case ($urandom_range(0, 5))
            0: return 32'(-131072);
            1: return 32'd131072;
            2: return 32'd0;
            3: return 32'($signed($urandom_range(0, 8)) - 4);
            default: return 32'($signed($urandom_range(0, 262144)) - 131072);
        endcase
    endfunction

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 4))
            0: return {10'd0, 22'h3FFFFF};
            1: return {10'd0, 6'($urandom_range(0, 63)), 16'h0000};
            default: return {10'd0, 22'($urandom())};
        endcase
    endfunction

    initial begin : stim
        int k;
        board.reset_regs();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, edge columns and columns past the screen.
        send_column(10'd0); send_column(10'd319); send_column(10'd320);
        send_column(10'd639); send_column(10'd640); send_column(10'd1023);
        drain();
        // Zero and one-LSB ray components, position at cell edges.
        set_view(32'h0001_0000, 32'h0000_0000, 32'd0, 32'd1, 32'd0, 32'd0);
        send_column(10'd320); send_column(10'd0);
        drain();
        set_view(32'h003F_FFFF, 32'h0020_8000, 32'(-1), 32'(-131072), 32'd131072,
                 32'(-131072));
        send_column(10'd0); send_column(10'd320); send_column(10'd639);
        send_column(10'd1023); send_column(10'd512);
        drain();
        // Large direction and plane values with an edge column and columns past the screen edge.
        set_view(32'h0000_0000, 32'h003F_FFFF, 32'd131072, 32'(-131072), 32'd131072,
                 32'd131072);
        send_column(10'd1023); send_column(10'd0); send_column(10'd700);
        drain();

        // Random phases with new settings in between.
        for (int ph = 0; ph < 17; ph++) begin
            if (ph == 14) calm = 1'b1;
            set_view(rand_pos(), rand_pos(), rand_dir(), rand_dir(), rand_dir(), rand_dir());
            if (ph == 3) hold_off = 1'b1;
            for (k = 0; k < 100; k++)
                send_column(($urandom_range(0, 9) == 0) ? 10'($urandom_range(640, 1023))
                                                        : 10'($urandom_range(0, 639)));
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb_raycast_ray_setup_core: done, clean");
        else
            $display("tb_raycast_ray_setup_core: done, errors");
        $finish;
    end
endmodule

[files.f]
src/rrs_pkg.sv
src/rrs_in_if.sv
src/rrs_out_if.sv
src/rrs_cfg.sv
src/rrs_ray.sv
src/rrs_div_stage.sv
src/rrs_side.sv
src/raycast_ray_setup_core.sv
sim/tb_raycast_ray_setup_core.sv
